>>> rtl/tnc_pkg.sv
// Shared constants, types and helpers for the toroidal neighbor counter.
// Used by tnc_front, tnc_fifo, tnc_back and toroidal_neighbor_counter_top.
package tnc_pkg;

  // Board and neighborhood limits
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_RADIUS = 7;

  // Fixed field widths of the ports
  localparam int XY_W      = 8;
  localparam int DIM_W     = 9;
  localparam int RAD_W     = 3;
  localparam int CNT_W     = 8;
  localparam int CFG_IDX_W = 8;

  // Derived widths
  localparam int CX_W      = $clog2(MAX_WIDTH);
  localparam int CY_W      = $clog2(MAX_HEIGHT);
  localparam int MAP_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);
  localparam int R_W       = $clog2(MAX_RADIUS + 1);
  localparam int OFS_W     = R_W + 1;
  localparam int DSUM_W    = R_W + 2;
  localparam int STEP_W    = $clog2(XY_W);
  localparam int AR_W      = 16;
  localparam int MAX_COUNT = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) - 1;

  // Queue between front and back (power of two)
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOARD_WIDTH  = 8'd0,
    REG_BOARD_HEIGHT = 8'd1,
    REG_RADIUS       = 8'd2,
    REG_NBR_KIND     = 8'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // Effective configuration after clamping
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [R_W-1:0]   radius;
    logic             diamond;
  } cfg_t;

  // One classified item, coordinates already wrapped onto the board
  typedef struct packed {
    op_t             op;
    logic [CX_W-1:0] cx;
    logic [CY_W-1:0] cy;
    logic            alive;
  } q_item_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_WALK,
    B_DRAIN,
    B_FINISH
  } back_state_t;

  // Linear board address of a cell
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [CX_W-1:0] cx,
                                                  input logic [CY_W-1:0] cy);
    logic [31:0] full;
    full = 32'(cy) * 32'(MAX_WIDTH) + 32'(cx);
    return full[ADDR_W-1:0];
  endfunction

endpackage

>>> rtl/tnc_front.sv
// Front part: accepts input beats and wraps the coordinates onto the board.
// Uses tnc_pkg; feeds tnc_fifo.
module tnc_front (
  input  logic             clk,
  input  logic             rst,
  input  tnc_pkg::cfg_t    cfg,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             op,
  input  logic [7:0]       x,
  input  logic [7:0]       y,
  input  logic             cell_alive,
  output logic             push,
  output tnc_pkg::q_item_t push_item,
  input  logic             q_full
);
  import tnc_pkg::*;

  front_state_t      state, state_next;
  op_t               op_r;
  logic              alive_r;
  logic [XY_W-1:0]   xs, ys;
  logic [CX_W-1:0]   xr, xr_next;
  logic [CY_W-1:0]   yr, yr_next;
  logic [STEP_W-1:0] step;
  logic              accept, fast;
  logic [AR_W-1:0]   x_try, y_try;

  assign in_stall = (state != F_IDLE);
  assign accept   = in_valid && !in_stall;
  assign fast     = (AR_W'(x) < AR_W'(cfg.width)) && (AR_W'(y) < AR_W'(cfg.height));

  // One restoring remainder step per cycle on both coordinates
  always_comb begin
    x_try   = AR_W'({xr, xs[XY_W-1]});
    y_try   = AR_W'({yr, ys[XY_W-1]});
    xr_next = (x_try >= AR_W'(cfg.width)) ? CX_W'(x_try - AR_W'(cfg.width)) : CX_W'(x_try);
    yr_next = (y_try >= AR_W'(cfg.height)) ? CY_W'(y_try - AR_W'(cfg.height)) : CY_W'(y_try);
  end

  // Hold the item; seed or advance the remainders
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= op_t'(op);
      alive_r <= cell_alive;
      xs      <= x;
      ys      <= y;
      step    <= '0;
      if (fast) begin
        xr <= CX_W'(x);
        yr <= CY_W'(y);
      end else begin
        xr <= '0;
        yr <= '0;
      end
    end else if (state == F_DIV) begin
      xr   <= xr_next;
      yr   <= yr_next;
      xs   <= xs << 1;
      ys   <= ys << 1;
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence: accept, divide when off the board, push to the queue
  always_comb begin
    state_next = state;
    push       = 1'b0;
    case (state)
      F_IDLE: begin
        if (accept) begin
          state_next = fast ? F_PUSH : F_DIV;
        end
      end
      F_DIV: begin
        if (step == STEP_W'(XY_W - 1)) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          push       = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  assign push_item = '{op: op_r, cx: xr, cy: yr, alive: alive_r};

endmodule

>>> rtl/tnc_fifo.sv
// Short queue of classified items between front and back.
// Uses tnc_pkg for the item type and depth.
module tnc_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tnc_pkg::q_item_t push_item,
  output logic             full,
  input  logic             pop,
  output tnc_pkg::q_item_t pop_item,
  output logic             empty
);
  import tnc_pkg::*;

  q_item_t            slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_PTR_W:0]   fill;

  assign full     = (fill == (Q_PTR_W + 1)'(Q_DEPTH));
  assign empty    = (fill == '0);
  assign pop_item = slots[rd_ptr];

  // Store incoming beats
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> rtl/tnc_back.sv
// Back part: owns the board memory, stores writes and walks query neighborhoods.
// Uses tnc_pkg; drains tnc_fifo and drives the result channel.
module tnc_back (
  input  logic             clk,
  input  logic             rst,
  input  tnc_pkg::cfg_t    cfg,
  input  logic             q_empty,
  input  tnc_pkg::q_item_t q_item,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       alive_count
);
  import tnc_pkg::*;

  logic                    board [MAP_DEPTH];
  back_state_t             state, state_next;
  logic [CX_W-1:0]         nx, nx0, nx_step;
  logic [CY_W-1:0]         ny, ny0, ny_step, ny_start;
  logic signed [OFS_W-1:0] dx, dy, r_ext;
  logic [R_W-1:0]          adx, ady;
  logic [DSUM_W-1:0]       dsum;
  logic [AR_W-1:0]         nx_sum, ny_sum, nx_inc, ny_inc;
  logic [ADDR_W-1:0]       addr;
  logic                    wr_en, start, incl, last_dy, last, load_out;
  logic                    rd_valid, rd_incl, rd_data;
  logic [CNT_W-1:0]        count;

  assign r_ext = $signed({1'b0, cfg.radius});
  assign pop   = (state == B_IDLE) && !q_empty;
  assign wr_en = pop && (q_item.op == OP_WRITE);
  assign start = pop && (q_item.op == OP_QUERY);

  // Corner of the walk: centre minus radius, wrapped
  always_comb begin
    nx_sum = AR_W'(q_item.cx) + AR_W'(cfg.width) - AR_W'(cfg.radius);
    ny_sum = AR_W'(q_item.cy) + AR_W'(cfg.height) - AR_W'(cfg.radius);
    nx0 = (nx_sum >= AR_W'(cfg.width)) ? CX_W'(nx_sum - AR_W'(cfg.width)) : CX_W'(nx_sum);
    ny0 = (ny_sum >= AR_W'(cfg.height)) ? CY_W'(ny_sum - AR_W'(cfg.height)) : CY_W'(ny_sum);
  end

  // Wrapping increments of the walk position
  always_comb begin
    nx_inc  = AR_W'(nx) + 1'b1;
    ny_inc  = AR_W'(ny) + 1'b1;
    nx_step = (nx_inc == AR_W'(cfg.width)) ? '0 : CX_W'(nx_inc);
    ny_step = (ny_inc == AR_W'(cfg.height)) ? '0 : CY_W'(ny_inc);
  end

  // Drop the centre and, for the diamond, the corners beyond the radius
  always_comb begin
    adx     = dx[OFS_W-1] ? R_W'(-dx) : R_W'(dx);
    ady     = dy[OFS_W-1] ? R_W'(-dy) : R_W'(dy);
    dsum    = DSUM_W'(adx) + DSUM_W'(ady);
    incl    = !((dx == '0) && (dy == '0)) && !(cfg.diamond && (dsum > DSUM_W'(cfg.radius)));
    last_dy = (dy == r_ext);
    last    = last_dy && (dx == r_ext);
  end

  assign addr = (state == B_IDLE) ? cell_addr(q_item.cx, q_item.cy) : cell_addr(nx, ny);

  // Board memory: one write and one registered read per cycle, at one address
  always_ff @(posedge clk) begin
    if (wr_en) begin
      board[addr] <= q_item.alive;
    end
    rd_data <= board[addr];
  end

  // Walk offsets and positions, column by column
  always_ff @(posedge clk) begin
    rd_incl <= incl;
    if (start) begin
      nx       <= nx0;
      ny       <= ny0;
      ny_start <= ny0;
      dx       <= -r_ext;
      dy       <= -r_ext;
    end else if (state == B_WALK) begin
      if (last_dy) begin
        nx <= nx_step;
        ny <= ny_start;
        dx <= dx + 1'b1;
        dy <= -r_ext;
      end else begin
        ny <= ny_step;
        dy <= dy + 1'b1;
      end
    end
  end

  // Accumulate alive neighbors, saturating
  always_ff @(posedge clk) begin
    if (start) begin
      count <= '0;
    end else if (rd_valid && rd_incl && rd_data && (count != '1)) begin
      count <= count + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      alive_count <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == B_WALK);
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Sequence: pop, walk, let the last read land, hand over the count
  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    case (state)
      B_IDLE: begin
        if (start) begin
          state_next = B_WALK;
        end
      end
      B_WALK: begin
        if (last) begin
          state_next = B_DRAIN;
        end
      end
      B_DRAIN: state_next = B_FINISH;
      B_FINISH: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

endmodule

>>> rtl/toroidal_neighbor_counter_top.sv
// Toroidal neighbor counter: a front that wraps coordinates, a queue, and a
// back that owns the board memory. Query time is set by the single read port
// of the board memory that the back walks one neighbor position a cycle; the
// front adds a bit-serial remainder when x or y lies beyond the configured
// board. The board needs no clearing after reset; the user must write a cell
// before a query reads it, which the block itself does not enforce.
// Configuration writes are always ready and must be issued only while the
// block is idle.
module toroidal_neighbor_counter_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tnc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tnc_pkg::DIM_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic [7:0]                    x,
  input  logic [7:0]                    y,
  input  logic                          cell_alive,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    alive_count
);
  import tnc_pkg::*;

  logic [DIM_W-1:0] board_width, board_height;
  logic [RAD_W-1:0] radius;
  logic             neighborhood_kind;
  logic [DIM_W-1:0] eff_w, eff_h;
  logic [AR_W-1:0]  eff_r;
  cfg_t             cfg;
  logic             q_push, q_full, q_pop, q_empty;
  q_item_t          q_in, q_out;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      board_width       <= DIM_W'(256);
      board_height      <= DIM_W'(256);
      radius            <= RAD_W'(1);
      neighborhood_kind <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_BOARD_WIDTH:  board_width       <= cfg_data;
        REG_BOARD_HEIGHT: board_height      <= cfg_data;
        REG_RADIUS:       radius            <= cfg_data[RAD_W-1:0];
        REG_NBR_KIND:     neighborhood_kind <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp board size and radius
  always_comb begin
    eff_w = (board_width == '0) ? DIM_W'(1) :
            ((AR_W'(board_width) > AR_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : board_width);
    eff_h = (board_height == '0) ? DIM_W'(1) :
            ((AR_W'(board_height) > AR_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : board_height);
    eff_r = AR_W'(radius);
    if (eff_r > AR_W'(MAX_RADIUS)) begin
      eff_r = AR_W'(MAX_RADIUS);
    end
    if (eff_r > AR_W'(eff_w)) begin
      eff_r = AR_W'(eff_w);
    end
    if (eff_r > AR_W'(eff_h)) begin
      eff_r = AR_W'(eff_h);
    end
    cfg = '{width: eff_w, height: eff_h, radius: R_W'(eff_r), diamond: neighborhood_kind};
  end

  tnc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .x          (x),
    .y          (y),
    .cell_alive (cell_alive),
    .push       (q_push),
    .push_item  (q_in),
    .q_full     (q_full)
  );

  tnc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out),
    .empty     (q_empty)
  );

  tnc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .q_item      (q_out),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .alive_count (alive_count)
  );

`ifndef SYNTHESIS
  // Queue never written when full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue push while full");

  // Queue never read when empty
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("queue pop while empty");

  // A count never exceeds the largest neighborhood
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (AR_W'(alive_count) <= AR_W'(MAX_COUNT)))
    else $error("alive count beyond neighborhood size");
`endif

endmodule

>>> bench/neighbor_count_checker.sv
// Checker for the toroidal neighbor counter: follows the register, item and
// result channels, predicts every neighbor count and compares each result beat.
// Depends on tnc_pkg for register indexes, op codes and board limits.
module neighbor_count_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [tnc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tnc_pkg::DIM_W-1:0]     cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          op,
  input  logic [7:0]                    x,
  input  logic [7:0]                    y,
  input  logic                          cell_alive,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [7:0]                    alive_count,
  output int                            mismatches,
  output int                            counts_waiting
);
  import tnc_pkg::*;

  localparam int PRINT_CAP = 40;

  bit               alive_board [MAP_DEPTH];
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [RAD_W-1:0] radius_reg;
  logic             diamond_reg;
  logic [7:0]       expected_counts [$];
  int               error_total = 0;

  assign mismatches = error_total;

  // Print one line per mismatch (up to a cap) and count every one
  task automatic report_mismatch(input string what);
    error_total++;
    if (error_total <= PRINT_CAP)
      $display("mismatch at %0t: %s", $time, what);
  endtask

  // Board size in use: zero counts as one, anything past the limit as the limit
  function automatic int board_dim(input logic [DIM_W-1:0] raw, input int limit);
    if (raw == '0)
      return 1;
    if (int'(raw) > limit)
      return limit;
    return int'(raw);
  endfunction

  // Count alive cells around (px,py) on the wrapping board, centre excluded
  function automatic logic [7:0] count_alive_around(input logic [7:0] px,
                                                    input logic [7:0] py);
    int w, h, cx, cy, reach, dx, dy, ax, ay, nx, ny, total;
    w = board_dim(width_reg, MAX_WIDTH);
    h = board_dim(height_reg, MAX_HEIGHT);
    cx = int'(px) % w;
    cy = int'(py) % h;
    reach = int'(radius_reg);
    if (reach > MAX_RADIUS)
      reach = MAX_RADIUS;
    if (reach > w)
      reach = w;
    if (reach > h)
      reach = h;
    total = 0;
    for (dx = -reach; dx <= reach; dx++) begin
      for (dy = -reach; dy <= reach; dy++) begin
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        // skip the centre and, for the diamond, the square's corners
        if (!(dx == 0 && dy == 0) && !(diamond_reg && (ax + ay > reach))) begin
          nx = (cx + dx + w) % w;
          ny = (cy + dy + h) % h;
          if (alive_board[ny * MAX_WIDTH + nx])
            total++;
        end
      end
    end
    if (total > 255)
      total = 255;
    return 8'(total);
  endfunction

  // Follow all three channels at each edge
  always @(posedge clk) begin : watch_channels
    int         w, h;
    logic [7:0] want;
    if (rst) begin
      width_reg   = DIM_W'(MAX_WIDTH);
      height_reg  = DIM_W'(MAX_HEIGHT);
      radius_reg  = RAD_W'(1);
      diamond_reg = 1'b0;
      expected_counts.delete();
    end else begin
      // compare a result beat with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_counts.size() == 0) begin
          report_mismatch($sformatf("alive_count %0d with no query waiting", alive_count));
        end else begin
          want = expected_counts.pop_front();
          if (alive_count !== want)
            report_mismatch($sformatf("alive_count got %0d, expected %0d",
                                      alive_count, want));
        end
      end
      // apply a register write; indexes past the list do nothing
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BOARD_WIDTH:  width_reg = cfg_data;
          REG_BOARD_HEIGHT: height_reg = cfg_data;
          REG_RADIUS:       radius_reg = cfg_data[RAD_W-1:0];
          REG_NBR_KIND:     diamond_reg = cfg_data[0];
          default: ;
        endcase
      end
      // store a cell or queue the count a query will return
      if (in_valid && !in_stall) begin
        if (op == OP_QUERY) begin
          expected_counts.push_back(count_alive_around(x, y));
        end else begin
          w = board_dim(width_reg, MAX_WIDTH);
          h = board_dim(height_reg, MAX_HEIGHT);
          alive_board[(int'(y) % h) * MAX_WIDTH + int'(x) % w] = cell_alive;
        end
      end
    end
    counts_waiting <= expected_counts.size();
  end

endmodule

>>> bench/toroidal_neighbor_counter_top_test.sv
// Testbench top for the toroidal neighbor counter: drives registers, cell
// writes and queries with random gaps and stalls, and gives the verdict.
// Depends on tnc_pkg, toroidal_neighbor_counter_top and neighbor_count_checker.
module toroidal_neighbor_counter_top_test;
  import tnc_pkg::*;

  localparam int RUN_LIMIT     = 2_000_000;
  localparam int SETTLE_CYCLES = 150;
  localparam int ITEM_BUDGET   = 1900;
  localparam int ROAM_AREA     = 1024;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_OF_LIST = 8'd200;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 op;
  logic [7:0]           x;
  logic [7:0]           y;
  logic                 cell_alive;
  logic                 out_valid;
  logic                 out_stall;
  logic [7:0]           alive_count;
  int                   mismatches;
  int                   counts_waiting;

  // Cells already written, so that no query ever reads a fresh cell
  bit written_cells [MAP_DEPTH];
  int board_w;
  int board_h;
  int reach;
  int alive_pct;
  int walk_x;
  int walk_y;
  int items_sent;
  bit idle_sender;
  bit idle_receiver;

  toroidal_neighbor_counter_top u_top (.*);

  neighbor_count_checker u_checker (.*);

  // Clock
  initial begin : clock_gen
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // End the run if it never finishes
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // Result side: stall a random number of cycles before each beat
  initial begin : result_sink
    int hold;
    out_stall <= 1'b1;
    @(posedge clk);
    forever begin
      hold = idle_receiver ? $urandom_range(0, 5) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Send one item beat after a random gap; hold it while stalled
  task automatic send_item(input op_t code, input logic [7:0] px, input logic [7:0] py,
                           input logic alive);
    int gap;
    gap = idle_sender ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= code;
    x          <= px;
    y          <= py;
    cell_alive <= alive;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Write one register, then drop valid for a cycle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [DIM_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait for every count to come back, then let writes finish
  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (counts_waiting != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Random raw coordinate that wraps onto board coordinate c
  function automatic logic [7:0] alias_coord(input int c, input int dim);
    int laps;
    laps = (255 - c) / dim;
    return 8'(c + dim * int'($urandom_range(0, laps)));
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim(input int limit);
    case ($urandom_range(0, 9))
      0:       return DIM_W'($urandom_range(0, 1));
      1:       return DIM_W'($urandom_range(limit - 1, (1 << DIM_W) - 1));
      default: return DIM_W'($urandom_range(2, 16));
    endcase
  endfunction

  task automatic store_cell(input int cx, input int cy, input logic alive);
    send_item(OP_WRITE, alias_coord(cx, board_w), alias_coord(cy, board_h), alive);
    written_cells[cy * MAX_WIDTH + cx] = 1'b1;
  endtask

  // Fill any fresh cell of the square around (cx,cy), then query it
  task automatic query_cell(input int cx, input int cy);
    int dx, dy, nx, ny;
    for (dx = -reach; dx <= reach; dx++) begin
      for (dy = -reach; dy <= reach; dy++) begin
        nx = (cx + dx + board_w) % board_w;
        ny = (cy + dy + board_h) % board_h;
        if (!written_cells[ny * MAX_WIDTH + nx])
          store_cell(nx, ny, $urandom_range(0, 99) < alive_pct);
      end
    end
    send_item(OP_QUERY, alias_coord(cx, board_w), alias_coord(cy, board_h),
              1'($urandom_range(0, 1)));
  endtask

  // One setting: write all registers while idle, then mix queries and writes
  task automatic run_phase(input logic [DIM_W-1:0] w_raw, input logic [DIM_W-1:0] h_raw,
                           input logic [DIM_W-1:0] r_raw, input logic [DIM_W-1:0] k_raw,
                           input int rounds, input int density);
    int  pick, step;
    bit  roam;
    wait_idle(SETTLE_CYCLES);
    write_reg(REG_BOARD_WIDTH, w_raw);
    write_reg(REG_BOARD_HEIGHT, h_raw);
    write_reg(REG_RADIUS, r_raw);
    write_reg(REG_NBR_KIND, k_raw);
    write_reg(REG_OUT_OF_LIST, DIM_W'($urandom));
    // mirror the clamping to plan which cells a query touches
    board_w = (w_raw == '0) ? 1 : ((int'(w_raw) > MAX_WIDTH) ? MAX_WIDTH : int'(w_raw));
    board_h = (h_raw == '0) ? 1 : ((int'(h_raw) > MAX_HEIGHT) ? MAX_HEIGHT : int'(h_raw));
    reach = int'(r_raw[RAD_W-1:0]);
    if (reach > MAX_RADIUS)
      reach = MAX_RADIUS;
    if (reach > board_w)
      reach = board_w;
    if (reach > board_h)
      reach = board_h;
    alive_pct     = density;
    idle_sender   = $urandom_range(0, 3) != 0;
    idle_receiver = $urandom_range(0, 3) != 0;
    roam   = board_w * board_h > ROAM_AREA;
    walk_x = $urandom_range(0, board_w - 1);
    walk_y = $urandom_range(0, board_h - 1);
    repeat (rounds) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // overwrite a cell anywhere on the board
        store_cell($urandom_range(0, board_w - 1), $urandom_range(0, board_h - 1),
                   $urandom_range(0, 99) < alive_pct);
      end else begin
        // on a large board creep along one axis to reuse written cells
        if (roam) begin
          step = int'($urandom_range(0, 2)) - 1;
          if ($urandom_range(0, 1) == 0)
            walk_x = (walk_x + step + board_w) % board_w;
          else
            walk_y = (walk_y + step + board_h) % board_h;
        end else begin
          walk_x = $urandom_range(0, board_w - 1);
          walk_y = $urandom_range(0, board_h - 1);
        end
        query_cell(walk_x, walk_y);
      end
      // now and then hold off until every count is back
      if ($urandom_range(0, 59) == 0)
        wait_idle(0);
    end
  endtask

  function automatic int pick_density();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 100;
      default: return $urandom_range(10, 90);
    endcase
  endfunction

  // Stimulus and verdict
  initial begin : stimulus
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    op            <= OP_WRITE;
    x             <= '0;
    y             <= '0;
    cell_alive    <= 1'b0;
    items_sent    = 0;
    idle_sender   = 1'b1;
    idle_receiver = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setting: full 256 x 256 board, radius 1, square, both corners
    board_w   = MAX_WIDTH;
    board_h   = MAX_HEIGHT;
    reach     = 1;
    alive_pct = 50;
    query_cell(0, 0);
    query_cell(MAX_WIDTH - 1, MAX_HEIGHT - 1);
    // single-cell board: every neighbor position folds onto the centre
    run_phase(DIM_W'(1), DIM_W'(1), DIM_W'(7), DIM_W'(0), 2, 100);
    // zero sizes count as one cell; radius 8 keeps only its low bits, so zero
    run_phase('0, '0, DIM_W'(8), DIM_W'(1), 2, 100);
    // width past the maximum, radius clamped by a two-row board, diamond
    run_phase(DIM_W'(511), DIM_W'(2), DIM_W'(7), DIM_W'(3), 2, 50);
    // largest count: full board, widest square, all cells alive
    run_phase(DIM_W'(MAX_WIDTH), DIM_W'(MAX_HEIGHT), DIM_W'(MAX_RADIUS), DIM_W'(0), 4, 100);

    // random settings until the item budget is spent
    while (items_sent < ITEM_BUDGET)
      run_phase(pick_dim(MAX_WIDTH), pick_dim(MAX_HEIGHT), DIM_W'($urandom),
                DIM_W'($urandom), $urandom_range(6, 24), pick_density());

    wait_idle(SETTLE_CYCLES);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
